### rtl/twdm_pkg.sv
package twdm_pkg;

    localparam int CMD_BITS     = 2;
    localparam int ADDR_BITS    = 7;
    localparam int WORD_BITS    = 32;
    localparam int CAPTURE_BITS = 36;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DAT_BITS = 16;
    localparam int ATT_BITS     = 8;

    typedef logic [5:0] t_slot;
    typedef logic [1:0] t_cause;

    localparam logic [CMD_BITS-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WRITE_ATTEMPTS = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_READ_ATTEMPTS  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BUSY_WAIT      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ERROR_WAIT     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GUARD          = 3'd4;

    localparam t_cause CAUSE_NONE   = 2'd0;
    localparam t_cause CAUSE_BUSY   = 2'd1;
    localparam t_cause CAUSE_ERROR  = 2'd2;
    localparam t_cause CAUSE_PARITY = 2'd3;

    localparam logic [1:0] STATUS_BUSY  = 2'd3;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam t_slot SLOT_ADDR_LAST   = 6'd6;
    localparam t_slot SLOT_OP          = 6'd7;
    localparam t_slot SLOT_ADDR_PAR    = 6'd8;
    localparam t_slot SLOT_TURN_FIRST  = 6'd9;
    localparam t_slot SLOT_TURN_LAST   = 6'd11;
    localparam t_slot SLOT_DATA_FIRST  = 6'd14;
    localparam t_slot SLOT_CAPT_FROM   = 6'd15;
    localparam t_slot SLOT_WDATA_LAST  = 6'd45;
    localparam t_slot SLOT_WDATA_PAR   = 6'd46;
    localparam t_slot SLOT_STATUS_1ST  = 6'd47;
    localparam t_slot SLOT_SAMPLE_LAST = 6'd49;
    localparam t_slot SLOT_TRAIL_ONE   = 6'd50;
    localparam t_slot SLOT_CAPT_TOP    = 6'd50;
    localparam t_slot FRAME_BITS       = 6'd52;
    localparam t_slot STOP_LAST        = 6'd2;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_START = 6'b000010,
        PH_BITS  = 6'b000100,
        PH_STOP  = 6'b001000,
        PH_GUARD = 6'b010000,
        PH_WAIT  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic sampled;
        logic host_bit;
    } t_slot_info;

    typedef struct packed {
        logic                 clock_level;
        logic                 data_level;
        logic                 data_enable;
        logic                 engine_busy;
        logic                 request_done;
        logic                 request_ok;
        logic [WORD_BITS-1:0] read_word;
        t_cause               fail_cause;
    } t_res;

endpackage

### rtl/twdm_req_if.sv
interface twdm_req_if;
    logic                           valid;
    logic                           ready;
    logic [twdm_pkg::CMD_BITS-1:0]  cmd;
    logic [twdm_pkg::ADDR_BITS-1:0] dmi_address;
    logic [twdm_pkg::WORD_BITS-1:0] write_value;
    logic                           line_sample;

    modport source (output valid, cmd, dmi_address, write_value, line_sample, input ready);
    modport sink   (input valid, cmd, dmi_address, write_value, line_sample, output ready);
endinterface

### rtl/twdm_res_if.sv
interface twdm_res_if;
    logic                           valid;
    logic                           ready;
    logic                           clock_level;
    logic                           data_level;
    logic                           data_enable;
    logic                           engine_busy;
    logic                           request_done;
    logic                           request_ok;
    logic [twdm_pkg::WORD_BITS-1:0] read_word;
    logic [1:0]                     fail_cause;

    modport source (output valid, clock_level, data_level, data_enable, engine_busy,
                    request_done, request_ok, read_word, fail_cause, input ready);
    modport sink   (input valid, clock_level, data_level, data_enable, engine_busy,
                    request_done, request_ok, read_word, fail_cause, output ready);
endinterface

### rtl/two_wire_dmi_master.sv
// Two-wire debug link master for single debug-module register accesses. A request beat
// (cmd write or read) loads the frame while the engine is idle and yields no result; every
// tick beat (cmd 0) advances the pins by one half bit period and yields exactly one result
// beat with clock level, data level, output enable and the finish report. One beat is taken
// per clock cycle: the frame sequencer is combinational and feeds an output register, so
// input ready drops only while that register is full and not taken. Configuration is
// written through the plain write port while the engine is idle; a user duty, not enforced.
module two_wire_dmi_master #(
    parameter int WAIT_COUNTER_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [twdm_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [twdm_pkg::CFG_DAT_BITS-1:0] i_cfg_data,
    twdm_req_if.sink                          i_req,
    twdm_res_if.source                        o_res
);
    import twdm_pkg::*;

    localparam int CW = (WAIT_COUNTER_BITS > CFG_DAT_BITS) ? WAIT_COUNTER_BITS : CFG_DAT_BITS;
    localparam logic [CW-1:0] WAIT_TOP = CW'({WAIT_COUNTER_BITS{1'b1}});

    function automatic logic [WAIT_COUNTER_BITS-1:0] wait_limit(input logic [CFG_DAT_BITS-1:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        if (ext > WAIT_TOP) begin
            ext = WAIT_TOP;
        end
        return WAIT_COUNTER_BITS'(ext);
    endfunction

    logic [ATT_BITS-1:0]     r_write_att, r_read_att;
    logic [CFG_DAT_BITS-1:0] r_busy_wait, r_error_wait, r_guard;

    t_phase                       r_phase, n_phase;
    t_slot                        r_slot, n_slot;
    logic                         r_half, n_half;
    logic                         r_write, n_write;
    logic [ADDR_BITS-1:0]         r_addr, n_addr;
    logic [WORD_BITS-1:0]         r_value, n_value;
    logic [CAPTURE_BITS-1:0]      r_cap, n_cap;
    logic [ATT_BITS-1:0]          r_att, n_att;
    logic [WAIT_COUNTER_BITS-1:0] r_wait, n_wait;
    logic                         r_last, n_last;

    logic       space;
    logic       accept;
    logic       tick;
    t_res       res;
    t_slot_info cur_info, prev_info;
    t_slot      prev_slot;
    t_slot      cap_pos;
    t_slot      next_slot;
    t_cause     cause;
    logic       limit_hit;
    logic       do_eval, do_after;
    logic [WAIT_COUNTER_BITS-1:0] guard_lim, retry_lim, dec_wait;

    assign i_req.ready = space;
    assign accept      = i_req.valid && space;
    assign tick        = accept && i_req.cmd == CMD_TICK;

    assign prev_slot = r_slot - 6'd1;
    assign cap_pos   = SLOT_CAPT_TOP - r_slot;
    assign next_slot = r_slot + 6'd1;

    twdm_slot_decode u_cur (
        .i_slot     (r_slot),
        .i_is_write (r_write),
        .i_addr     (r_addr),
        .i_value    (r_value),
        .o_info     (cur_info)
    );

    twdm_slot_decode u_prev (
        .i_slot     (prev_slot),
        .i_is_write (r_write),
        .i_addr     (r_addr),
        .i_value    (r_value),
        .o_info     (prev_info)
    );

    always_comb begin
        if (r_cap[1:0] == STATUS_BUSY) begin
            cause = CAUSE_BUSY;
        end else if (r_cap[1:0] == STATUS_ERROR) begin
            cause = CAUSE_ERROR;
        end else if (!r_write && r_cap[3] != ^r_cap[CAPTURE_BITS-1:4]) begin
            cause = CAUSE_PARITY;
        end else begin
            cause = CAUSE_NONE;
        end
    end

    assign limit_hit = r_att >= (r_write ? r_write_att : r_read_att);
    assign guard_lim = wait_limit(r_guard);
    assign retry_lim = wait_limit(cause == CAUSE_BUSY ? r_busy_wait : r_error_wait);
    assign dec_wait  = (r_wait != '0) ? r_wait - WAIT_COUNTER_BITS'(1) : r_wait;

    always_comb begin
        n_phase = r_phase;
        n_slot  = r_slot;
        n_half  = r_half;
        n_write = r_write;
        n_addr  = r_addr;
        n_value = r_value;
        n_cap   = r_cap;
        n_att   = r_att;
        n_wait  = r_wait;
        n_last  = r_last;
        do_eval  = 1'b0;
        do_after = 1'b0;

        res = '0;
        res.clock_level = 1'b1;
        res.data_level  = 1'b1;
        res.data_enable = 1'b1;

        if (accept && r_phase == PH_IDLE
                && (i_req.cmd == CMD_WRITE || i_req.cmd == CMD_READ)) begin
            n_write = i_req.cmd == CMD_WRITE;
            n_addr  = i_req.dmi_address;
            n_value = (i_req.cmd == CMD_WRITE) ? i_req.write_value : '0;
            n_att   = ATT_BITS'(1);
            n_phase = PH_START;
            n_half  = 1'b0;
            n_slot  = '0;
            n_cap   = '0;
        end

        if (tick) begin
            unique case (r_phase)
                PH_START: begin
                    res.data_level = !r_half;
                    n_last = !r_half;
                    if (r_half) begin
                        n_half  = 1'b0;
                        n_slot  = '0;
                        n_phase = PH_BITS;
                    end else begin
                        n_half = 1'b1;
                    end
                end
                PH_BITS: begin
                    if (r_slot >= FRAME_BITS) begin
                        n_phase = PH_STOP;
                        n_slot  = '0;
                    end else begin
                        if (!r_half && r_slot >= SLOT_CAPT_FROM && prev_info.sampled) begin
                            n_cap[cap_pos] = i_req.line_sample;
                        end
                        res.clock_level = r_half;
                        if (cur_info.sampled) begin
                            res.data_enable = 1'b0;
                            res.data_level  = r_last;
                        end else begin
                            res.data_level = cur_info.host_bit;
                            n_last = cur_info.host_bit;
                        end
                        if (r_half) begin
                            n_half = 1'b0;
                            if (next_slot >= FRAME_BITS) begin
                                n_phase = PH_STOP;
                                n_slot  = '0;
                            end else begin
                                n_slot = next_slot;
                            end
                        end else begin
                            n_half = 1'b1;
                        end
                    end
                end
                PH_STOP: begin
                    res.clock_level = r_slot != '0;
                    res.data_level  = r_slot >= STOP_LAST;
                    n_last = r_slot >= STOP_LAST;
                    if (r_slot >= STOP_LAST) begin
                        n_slot = '0;
                        if (guard_lim == '0) begin
                            do_eval = 1'b1;
                        end else begin
                            n_wait  = guard_lim;
                            n_phase = PH_GUARD;
                        end
                    end else begin
                        n_slot = next_slot;
                    end
                end
                PH_GUARD: begin
                    n_wait = dec_wait;
                    do_eval = dec_wait == '0;
                end
                PH_WAIT: begin
                    n_wait = dec_wait;
                    do_after = dec_wait == '0;
                end
                default: begin
                    n_phase = PH_IDLE;
                    res.data_level = r_last;
                end
            endcase

            if (do_eval) begin
                if (cause == CAUSE_NONE) begin
                    do_after = 1'b0;
                end else begin
                    n_wait = retry_lim;
                    if (retry_lim == '0) begin
                        do_after = 1'b1;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
            end

            if ((do_eval && cause == CAUSE_NONE) || (do_after && limit_hit)) begin
                n_phase          = PH_IDLE;
                res.request_done = 1'b1;
                res.request_ok   = cause == CAUSE_NONE;
                res.read_word    = (cause == CAUSE_NONE && !r_write) ?
                                   r_cap[CAPTURE_BITS-1:4] : '0;
                res.fail_cause   = cause;
            end else if (do_after) begin
                n_phase = PH_START;
                n_half  = 1'b0;
                n_slot  = '0;
                n_cap   = '0;
                n_att   = (r_att != '1) ? r_att + ATT_BITS'(1) : r_att;
            end

            res.engine_busy = n_phase != PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_slot  <= '0;
            r_half  <= 1'b0;
            r_write <= 1'b0;
            r_addr  <= '0;
            r_value <= '0;
            r_cap   <= '0;
            r_att   <= '0;
            r_wait  <= '0;
            r_last  <= 1'b1;
        end else begin
            r_phase <= n_phase;
            r_slot  <= n_slot;
            r_half  <= n_half;
            r_write <= n_write;
            r_addr  <= n_addr;
            r_value <= n_value;
            r_cap   <= n_cap;
            r_att   <= n_att;
            r_wait  <= n_wait;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_att  <= ATT_BITS'(16);
            r_read_att   <= ATT_BITS'(64);
            r_busy_wait  <= CFG_DAT_BITS'(200);
            r_error_wait <= CFG_DAT_BITS'(100);
            r_guard      <= CFG_DAT_BITS'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WRITE_ATTEMPTS: r_write_att  <= i_cfg_data[ATT_BITS-1:0];
                CFG_READ_ATTEMPTS:  r_read_att   <= i_cfg_data[ATT_BITS-1:0];
                CFG_BUSY_WAIT:      r_busy_wait  <= i_cfg_data;
                CFG_ERROR_WAIT:     r_error_wait <= i_cfg_data;
                CFG_GUARD:          r_guard      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    twdm_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (tick),
        .i_data  (res),
        .o_space (space),
        .o_res   (o_res)
    );

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.request_done |-> n_phase == PH_IDLE)
        else $error("finish report while engine stays busy");

    a_half_outside_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_START && r_phase != PH_BITS) |-> !r_half)
        else $error("half select set outside start or bit slots");

    a_stop_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_STOP |-> r_slot <= STOP_LAST)
        else $error("stop slot out of range");

    a_bits_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BITS |-> r_slot < FRAME_BITS)
        else $error("bit slot beyond frame");

    a_attempt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> r_att != '0)
        else $error("frame running with no attempt counted");

endmodule

### rtl/twdm_slot_decode.sv
module twdm_slot_decode (
    input  twdm_pkg::t_slot                  i_slot,
    input  logic                             i_is_write,
    input  logic [twdm_pkg::ADDR_BITS-1:0]   i_addr,
    input  logic [twdm_pkg::WORD_BITS-1:0]   i_value,
    output twdm_pkg::t_slot_info             o_info
);
    import twdm_pkg::*;

    t_slot addr_off;
    t_slot data_off;

    assign addr_off = SLOT_ADDR_LAST - i_slot;
    assign data_off = SLOT_WDATA_LAST - i_slot;

    always_comb begin
        if (i_slot >= SLOT_TURN_FIRST && i_slot <= SLOT_TURN_LAST) begin
            o_info.sampled = 1'b1;
        end else if (i_is_write) begin
            o_info.sampled = i_slot >= SLOT_STATUS_1ST && i_slot <= SLOT_SAMPLE_LAST;
        end else begin
            o_info.sampled = i_slot >= SLOT_DATA_FIRST && i_slot <= SLOT_SAMPLE_LAST;
        end

        if (i_slot <= SLOT_ADDR_LAST) begin
            o_info.host_bit = i_addr[addr_off[2:0]];
        end else if (i_slot == SLOT_OP) begin
            o_info.host_bit = i_is_write;
        end else if (i_slot == SLOT_ADDR_PAR) begin
            o_info.host_bit = (^i_addr) ^ i_is_write;
        end else if (i_is_write && i_slot >= SLOT_DATA_FIRST && i_slot <= SLOT_WDATA_LAST) begin
            o_info.host_bit = i_value[data_off[4:0]];
        end else if (i_is_write && i_slot == SLOT_WDATA_PAR) begin
            o_info.host_bit = ^i_value;
        end else begin
            o_info.host_bit = i_slot == SLOT_TRAIL_ONE;
        end
    end
endmodule

### rtl/twdm_outbuf.sv
module twdm_outbuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  twdm_pkg::t_res i_data,
    output logic           o_space,
    twdm_res_if.source     o_res
);
    import twdm_pkg::*;

    logic r_valid;
    t_res r_data;

    assign o_space = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.clock_level  = r_data.clock_level;
    assign o_res.data_level   = r_data.data_level;
    assign o_res.data_enable  = r_data.data_enable;
    assign o_res.engine_busy  = r_data.engine_busy;
    assign o_res.request_done = r_data.request_done;
    assign o_res.request_ok   = r_data.request_ok;
    assign o_res.read_word    = r_data.read_word;
    assign o_res.fail_cause   = r_data.fail_cause;
endmodule
